[rtl/key_debounce_long_press_events_core_defines.svh]
// assertion macros used by the checker file
`ifndef KEY_DEBOUNCE_LONG_PRESS_EVENTS_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_EVENTS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define KDLP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, sampled on clock, off during reset
`define KDLP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[rtl/kdlp_pkg.sv]
// shared types, constants and helpers of the key debounce block
`timescale 1ns / 1ps

package kdlp_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int FILT_W     = 8;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CH_NUM     = 3;
   localparam int CH_W       = 2;
   localparam int CODE_W     = 4;
   localparam int EVQ_DEPTH  = 6;
   localparam int EVQ_W      = 3;

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CH_NUM - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FILTER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REP_EN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MASK   = 3'd4;

   // event kinds, added to 3*channel
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_LONG    = 2'd2;
   localparam logic [1:0] EV_RELEASE = 2'd3;

   typedef struct packed {
      logic [FILT_W-1:0]     filter_ticks;
      logic [TIME_WIDTH-1:0] long_ticks;
      logic [TIME_WIDTH-1:0] repeat_ticks;
      logic                  repeat_enable;
      logic [1:0]            active_high_mask;
   } cfg_type;

   typedef struct packed {
      logic [FILT_W-1:0]     filter_count;
      logic                  pressed_flag;
      logic [TIME_WIDTH-1:0] hold_count;
      logic [TIME_WIDTH-1:0] repeat_count;
   } chan_state_type;

   // up to two events from one channel update, packed from slot 0
   typedef struct packed {
      logic              v0;
      logic [CODE_W-1:0] c0;
      logic              v1;
      logic [CODE_W-1:0] c1;
   } evt_push_type;

   localparam int STATE_W = $bits(chan_state_type);

   function automatic logic [CODE_W-1:0] ev_code(logic [CH_W-1:0] ch, logic [1:0] kind);
      return CODE_W'(3 * ch) + {2'b00, kind};
   endfunction

endpackage

[rtl/kdlp_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module kdlp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 4,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/kdlp_chan.sv]
// per-channel debounce, hold and repeat update of one state entry
`timescale 1ns / 1ps

module kdlp_chan (
   input  kdlp_pkg::cfg_type         cfg,
   input  logic [kdlp_pkg::CH_W-1:0] ch,
   input  logic                      act,
   input  kdlp_pkg::chan_state_type  cur,
   output kdlp_pkg::chan_state_type  nxt,
   output kdlp_pkg::evt_push_type    push
);

   logic                                 ev_press;
   logic                                 ev_other;
   logic [1:0]                           other_kind;
   logic [kdlp_pkg::TIME_WIDTH-1:0]      hold_inc;
   logic [kdlp_pkg::TIME_WIDTH-1:0]      rep_inc;

   assign hold_inc = cur.hold_count + kdlp_pkg::TIME_WIDTH'(1);
   assign rep_inc  = cur.repeat_count + kdlp_pkg::TIME_WIDTH'(1);

   always_comb begin
      nxt        = cur;
      ev_press   = 1'b0;
      ev_other   = 1'b0;
      other_kind = kdlp_pkg::EV_LONG;
      if (act) begin
         if (cur.filter_count < cfg.filter_ticks) begin
            nxt.filter_count = cur.filter_count + kdlp_pkg::FILT_W'(1);
         end else begin
            if (!cur.pressed_flag) begin
               nxt.pressed_flag = 1'b1;
               ev_press         = 1'b1;
            end
            if (cur.hold_count < cfg.long_ticks) begin
               nxt.hold_count = hold_inc;
               ev_other       = (hold_inc == cfg.long_ticks);
            end else if (cfg.repeat_enable) begin
               if (rep_inc >= cfg.repeat_ticks) begin
                  nxt.repeat_count = '0;
                  ev_other         = 1'b1;
               end else begin
                  nxt.repeat_count = rep_inc;
               end
            end
         end
      end else begin
         // release shows only once the filter count has been cleared
         if (cur.filter_count == '0 && cur.pressed_flag) begin
            nxt.pressed_flag = 1'b0;
            ev_other         = 1'b1;
            other_kind       = kdlp_pkg::EV_RELEASE;
         end
         nxt.filter_count = '0;
         nxt.hold_count   = '0;
         nxt.repeat_count = '0;
      end
   end

   // press goes first when both happen
   always_comb begin
      push = '0;
      if (ev_press) begin
         push.v0 = 1'b1;
         push.c0 = kdlp_pkg::ev_code(ch, kdlp_pkg::EV_PRESS);
         push.v1 = ev_other;
         push.c1 = kdlp_pkg::ev_code(ch, other_kind);
      end else begin
         push.v0 = ev_other;
         push.c0 = kdlp_pkg::ev_code(ch, other_kind);
      end
   end

endmodule

[rtl/kdlp_evq.sv]
// event queue that gathers the words of one tick before they drain
`timescale 1ns / 1ps

module kdlp_evq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  kdlp_pkg::evt_push_type      push,
   input  logic                        pop,
   output logic                        avail,
   output logic [kdlp_pkg::CODE_W-1:0] head_code,
   output logic                        head_last
);

   logic [kdlp_pkg::CODE_W-1:0] buf_ff [kdlp_pkg::EVQ_DEPTH];
   logic [kdlp_pkg::EVQ_W-1:0]  wr_ff;
   logic [kdlp_pkg::EVQ_W-1:0]  wr_in;
   logic [kdlp_pkg::EVQ_W-1:0]  rd_ff;
   logic [kdlp_pkg::EVQ_W-1:0]  rd_in;
   logic [kdlp_pkg::EVQ_W-1:0]  wr_next;

   assign wr_next = wr_ff + kdlp_pkg::EVQ_W'(1);

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (clear) begin
         wr_in = '0;
         rd_in = '0;
      end else begin
         wr_in = wr_ff + kdlp_pkg::EVQ_W'(push.v0) + kdlp_pkg::EVQ_W'(push.v1);
         if (pop) begin
            rd_in = rd_ff + kdlp_pkg::EVQ_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!clear && push.v0) begin
         buf_ff[wr_ff] <= push.c0;
      end
      if (!clear && push.v1) begin
         buf_ff[wr_next] <= push.c1;
      end
   end

   assign avail     = (rd_ff != wr_ff);
   assign head_code = buf_ff[rd_ff];
   assign head_last = (rd_ff + kdlp_pkg::EVQ_W'(1)) == wr_ff;

endmodule

[rtl/key_debounce_long_press_events_core.sv]
// Key debounce core: two key pins in, press / long / repeat / release events out.
//
// Input channel (req_): one word per scan tick with the raw pin levels of key 0
// and key 1. Result channel (rsp_): zero to six event words per tick, in channel
// order (key 0, key 1, combo), rsp_last_event set on the final word of a tick.
// Config (csr_): write enable, 3-bit register index, 16-bit data, taken on the
// clock edge; write only while the block is idle.
// Timing: the per-channel state sits in a 3-entry ram with registered read. The
// accept cycle reads channel 0, then each scan cycle updates and writes back one
// channel while reading the next, then the queued events drain at one word per
// cycle while the output is not stalled; req_stall is high from the accept until
// the queue has drained.
// The last word may still sit in the output register while the next tick is
// taken. A stalled output word holds and the drain waits on it.
// Reset (synchronous, active high) loads the register defaults and marks all
// three ram entries invalid, so they read as zero until first written.
`timescale 1ns / 1ps

module key_debounce_long_press_events_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_pin_level_a,
   input  logic                           req_pin_level_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kdlp_pkg::CODE_W-1:0]    rsp_event_code,
   output logic                           rsp_last_event,
   input  logic                           csr_wr_en,
   input  logic [kdlp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kdlp_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   kdlp_pkg::cfg_type              cfg_ff;
   logic [1:0]                     state_ff;
   logic [1:0]                     state_in;
   logic [kdlp_pkg::CH_W-1:0]      ch_ff;
   logic [kdlp_pkg::CH_W-1:0]      ch_in;
   logic [kdlp_pkg::CH_NUM-1:0]    act_ff;
   logic [kdlp_pkg::CH_NUM-1:0]    valid_ff;
   logic                           rd_valid_ff;
   logic                           rsp_valid_ff;
   logic [kdlp_pkg::CODE_W-1:0]    rsp_code_ff;
   logic                           rsp_last_ff;

   logic                           req_accept;
   logic                           rd_en;
   logic [kdlp_pkg::CH_W-1:0]      rd_addr;
   logic [kdlp_pkg::STATE_W-1:0]   rd_data;
   logic                           wr_en;
   kdlp_pkg::chan_state_type       cur_state;
   kdlp_pkg::chan_state_type       nxt_state;
   kdlp_pkg::evt_push_type         chan_push;
   kdlp_pkg::evt_push_type         q_push;
   logic                           q_avail;
   logic [kdlp_pkg::CODE_W-1:0]    q_code;
   logic                           q_last;
   logic                           q_pop;
   logic                           act_a;
   logic                           act_b;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_ticks     <= kdlp_pkg::FILT_W'(5);
         cfg_ff.long_ticks       <= kdlp_pkg::TIME_WIDTH'(100);
         cfg_ff.repeat_ticks     <= kdlp_pkg::TIME_WIDTH'(10);
         cfg_ff.repeat_enable    <= 1'b1;
         cfg_ff.active_high_mask <= 2'd2;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            kdlp_pkg::REG_FILTER: cfg_ff.filter_ticks <= csr_wr_data[kdlp_pkg::FILT_W-1:0];
            kdlp_pkg::REG_LONG:   cfg_ff.long_ticks   <= kdlp_pkg::TIME_WIDTH'(csr_wr_data);
            kdlp_pkg::REG_REPEAT: cfg_ff.repeat_ticks <= kdlp_pkg::TIME_WIDTH'(csr_wr_data);
            kdlp_pkg::REG_REP_EN: cfg_ff.repeat_enable <= csr_wr_data[0];
            kdlp_pkg::REG_MASK:   cfg_ff.active_high_mask <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   assign act_a = (req_pin_level_a == cfg_ff.active_high_mask[0]);
   assign act_b = (req_pin_level_b == cfg_ff.active_high_mask[1]);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff <= {act_a && act_b, act_b, act_a};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
               ch_in    = '0;
            end
         end
         ST_SCAN: begin
            if (ch_ff == kdlp_pkg::LAST_CH) begin
               state_in = ST_DRAIN;
            end else begin
               ch_in = ch_ff + kdlp_pkg::CH_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!q_avail) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   // read the next channel while the current one is written back
   assign rd_en   = req_accept || (state_ff == ST_SCAN && ch_ff != kdlp_pkg::LAST_CH);
   assign rd_addr = req_accept ? '0 : ch_ff + kdlp_pkg::CH_W'(1);
   assign wr_en   = (state_ff == ST_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[ch_ff] <= 1'b1;
         end
      end
   end

   kdlp_ram #(
      .WIDTH (kdlp_pkg::STATE_W),
      .DEPTH (kdlp_pkg::CH_NUM),
      .ADDR_W(kdlp_pkg::CH_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ch_ff),
      .wr_data(nxt_state),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // entries never written read as zero
   assign cur_state = rd_valid_ff ? kdlp_pkg::chan_state_type'(rd_data) : '0;

   kdlp_chan u_chan (
      .cfg (cfg_ff),
      .ch  (ch_ff),
      .act (act_ff[ch_ff]),
      .cur (cur_state),
      .nxt (nxt_state),
      .push(chan_push)
   );

   assign q_push = wr_en ? chan_push : '0;
   assign q_pop  = (state_ff == ST_DRAIN) && q_avail && (!rsp_valid_ff || !rsp_stall);

   kdlp_evq u_evq (
      .clock    (clock),
      .reset    (reset),
      .clear    (req_accept),
      .push     (q_push),
      .pop      (q_pop),
      .avail    (q_avail),
      .head_code(q_code),
      .head_last(q_last)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_code_ff <= q_code;
         rsp_last_ff <= q_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_last_event = rsp_last_ff;

endmodule

[rtl/kdlp_checker.sv]
// port-level checks of the key debounce core, bound to its top level
`timescale 1ns / 1ps
`include "key_debounce_long_press_events_core_defines.svh"

module kdlp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [kdlp_pkg::CODE_W-1:0]    rsp_event_code,
   input logic                           rsp_last_event
);

   logic in_take;
   logic out_take;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   // a stalled word stays and holds
   `KDLP_ASSERT_NXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
   `KDLP_ASSERT_NXT(a_rsp_hold_code, rsp_valid && rsp_stall, $stable(rsp_event_code))
   // codes stay within the three channels
   `KDLP_ASSERT_IMP(a_code_range, rsp_valid, rsp_event_code >= 4'd1 && rsp_event_code <= 4'd9)
   // a tick is worked on alone
   `KDLP_ASSERT_NXT(a_busy_after_take, in_take, req_stall)
   // words of one tick come out without gaps
   `KDLP_ASSERT_NXT(a_no_gap_in_tick, out_take && !rsp_last_event, rsp_valid)

endmodule

bind key_debounce_long_press_events_core kdlp_checker u_kdlp_checker (.*);

[dv/key_debounce_long_press_events_core_test.sv]
// self-checking testbench for the key debounce core: scan ticks in, key events checked
`timescale 1ns / 1ps

module key_debounce_long_press_events_core_test;

   localparam int RUN_LIMIT     = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_WAIT      = 6;
   localparam int SPARE_NUM     = 3;
   localparam int RAND_PHASES   = 6;
   // first index with no register
   localparam logic [kdlp_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd5;

   typedef struct packed {
      logic pin_a;
      logic pin_b;
   } tick_word_type;

   typedef struct packed {
      logic [kdlp_pkg::CODE_W-1:0] code;
      logic                        last;
   } event_word_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_pin_level_a = 1'b0;
   logic                           req_pin_level_b = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [kdlp_pkg::CODE_W-1:0]    rsp_event_code;
   logic                           rsp_last_event;
   logic                           csr_wr_en = 1'b0;
   logic [kdlp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [kdlp_pkg::CSR_W-1:0]     csr_wr_data = '0;

   tick_word_type            tick_q[$];
   event_word_type           key_event_q[$];
   kdlp_pkg::cfg_type        cfg_mirror;
   kdlp_pkg::chan_state_type chan_mirror [kdlp_pkg::CH_NUM];

   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;
   int idle_left = 0;
   int stall_left = 0;
   int errors = 0;
   int ticks_sent = 0;
   int events_seen = 0;
   int settings_run = 0;
   int cycle_count = 0;

   key_debounce_long_press_events_core DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void push_event(logic [kdlp_pkg::CODE_W-1:0] code);
      key_event_q.push_back('{code: code, last: 1'b0});
   endfunction

   // runs one scan tick through the mirrored channel state, queues the events it causes
   function automatic void predict_key_events(logic pin_a, logic pin_b);
      logic [kdlp_pkg::CH_NUM-1:0] active;
      logic [kdlp_pkg::CODE_W-1:0] base;
      kdlp_pkg::chan_state_type    st;
      event_word_type              tail;
      int                          first_new;
      first_new = key_event_q.size();
      active[0] = (pin_a == cfg_mirror.active_high_mask[0]);
      active[1] = (pin_b == cfg_mirror.active_high_mask[1]);
      active[2] = active[0] & active[1];
      for (int ch = 0; ch < kdlp_pkg::CH_NUM; ch++) begin
         st = chan_mirror[ch];
         base = kdlp_pkg::CODE_W'(3 * ch);
         if (active[ch]) begin
            if (st.filter_count < cfg_mirror.filter_ticks) begin
               st.filter_count = st.filter_count + 1'b1;
            end else begin
               if (!st.pressed_flag) begin
                  st.pressed_flag = 1'b1;
                  push_event(base + kdlp_pkg::EV_PRESS);
               end
               if (st.hold_count < cfg_mirror.long_ticks) begin
                  st.hold_count = st.hold_count + 1'b1;
                  if (st.hold_count == cfg_mirror.long_ticks)
                     push_event(base + kdlp_pkg::EV_LONG);
               end else if (cfg_mirror.repeat_enable) begin
                  st.repeat_count = st.repeat_count + 1'b1;
                  if (st.repeat_count >= cfg_mirror.repeat_ticks) begin
                     st.repeat_count = '0;
                     push_event(base + kdlp_pkg::EV_LONG);
                  end
               end
            end
         end else begin
            // release only once the filter count has already been cleared
            if (st.filter_count == '0 && st.pressed_flag) begin
               st.pressed_flag = 1'b0;
               push_event(base + kdlp_pkg::EV_RELEASE);
            end
            st.filter_count = '0;
            st.hold_count = '0;
            st.repeat_count = '0;
         end
         chan_mirror[ch] = st;
      end
      if (key_event_q.size() > first_new) begin
         tail = key_event_q.pop_back();
         tail.last = 1'b1;
         key_event_q.push_back(tail);
      end
   endfunction

   function automatic void log_mismatch(string text);
      errors++;
      if (errors <= 10) $display("mismatch: %s", text);
   endfunction

   function automatic void add_tick(logic pin_a, logic pin_b);
      tick_q.push_back('{pin_a: pin_a, pin_b: pin_b});
   endfunction

   // mostly held key patterns of random length, with single-tick glitches mixed in
   function automatic void add_random_ticks(int count);
      tick_word_type held;
      int            run_len;
      while (count > 0) begin
         held = tick_word_type'(2'($urandom_range(0, 3)));
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
         for (int k = 0; k < run_len && count > 0; k++) begin
            if ($urandom_range(0, 9) == 0)
               tick_q.push_back(tick_word_type'(2'($urandom_range(0, 3))));
            else tick_q.push_back(held);
            count--;
         end
      end
   endfunction

   // upper data bits beyond a register's width are random and must be dropped
   task automatic write_reg(logic [kdlp_pkg::CSR_IDX_W-1:0] idx,
                            logic [kdlp_pkg::CSR_W-1:0] value);
      logic [kdlp_pkg::CSR_W-1:0] data;
      data = kdlp_pkg::CSR_W'($urandom);
      unique case (idx)
         kdlp_pkg::REG_FILTER: begin
            data[kdlp_pkg::FILT_W-1:0] = value[kdlp_pkg::FILT_W-1:0];
            cfg_mirror.filter_ticks = value[kdlp_pkg::FILT_W-1:0];
         end
         kdlp_pkg::REG_LONG: begin
            data = value;
            cfg_mirror.long_ticks = value[kdlp_pkg::TIME_WIDTH-1:0];
         end
         kdlp_pkg::REG_REPEAT: begin
            data = value;
            cfg_mirror.repeat_ticks = value[kdlp_pkg::TIME_WIDTH-1:0];
         end
         kdlp_pkg::REG_REP_EN: begin
            data[0] = value[0];
            cfg_mirror.repeat_enable = value[0];
         end
         kdlp_pkg::REG_MASK: begin
            data[1:0] = value[1:0];
            cfg_mirror.active_high_mask = value[1:0];
         end
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
   endtask

   task automatic write_config(logic [kdlp_pkg::FILT_W-1:0] filt,
                               logic [kdlp_pkg::TIME_WIDTH-1:0] hold_t,
                               logic [kdlp_pkg::TIME_WIDTH-1:0] rep_t,
                               logic rep_en, logic [1:0] mask);
      write_reg(kdlp_pkg::REG_FILTER, kdlp_pkg::CSR_W'(filt));
      write_reg(kdlp_pkg::REG_LONG, kdlp_pkg::CSR_W'(hold_t));
      write_reg(kdlp_pkg::REG_REPEAT, kdlp_pkg::CSR_W'(rep_t));
      write_reg(kdlp_pkg::REG_REP_EN, kdlp_pkg::CSR_W'(rep_en));
      write_reg(kdlp_pkg::REG_MASK, kdlp_pkg::CSR_W'(mask));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   // sender holds off until every queued word is out and every event has come back
   task automatic wait_idle();
      while (tick_q.size() != 0 || req_valid || key_event_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : tick_driver
      tick_word_type next_tick;
      int            wait_now;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left <= 0;
      end else if (!req_valid || !req_stall) begin
         wait_now = idle_left;
         if (req_valid) begin
            predict_key_events(req_pin_level_a, req_pin_level_b);
            ticks_sent++;
            wait_now = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (wait_now > 0) begin
            req_valid <= 1'b0;
            idle_left <= wait_now - 1;
         end else if (tick_q.size() > 0) begin
            next_tick = tick_q.pop_front();
            req_valid <= 1'b1;
            req_pin_level_a <= next_tick.pin_a;
            req_pin_level_b <= next_tick.pin_b;
            idle_left <= 0;
         end else begin
            req_valid <= 1'b0;
            idle_left <= 0;
         end
      end
   end

   always @(posedge clock) begin : event_monitor
      event_word_type want;
      int             hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         hold = stall_left;
         if (rsp_valid && !rsp_stall) begin
            events_seen++;
            if (key_event_q.size() == 0) begin
               log_mismatch($sformatf("unexpected event word code %0d last %0d",
                                      rsp_event_code, rsp_last_event));
            end else begin
               want = key_event_q.pop_front();
               if (rsp_event_code !== want.code || rsp_last_event !== want.last)
                  log_mismatch($sformatf("expected code %0d last %0d, got code %0d last %0d",
                                         want.code, want.last, rsp_event_code, rsp_last_event));
            end
            hold = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      cfg_mirror = '{filter_ticks: 8'd5, long_ticks: 16'd100, repeat_ticks: 16'd10,
                     repeat_enable: 1'b1, active_high_mask: 2'b10};
      for (int ch = 0; ch < kdlp_pkg::CH_NUM; ch++) chan_mirror[ch] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: key 0 active low, key 1 active high; press on the sixth tick
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (6) add_tick(1'b0, 1'b1);
      add_tick(1'b1, 1'b1);
      add_tick(1'b1, 1'b0);
      add_tick(1'b0, 1'b0);
      add_tick(1'b1, 1'b0);
      settings_run++;
      wait_idle();

      // no filter, no long time, no repeat period: press and repeat on every active tick
      for (int k = 0; k < SPARE_NUM; k++)
         write_reg(REG_SPARE + kdlp_pkg::CSR_IDX_W'(k), kdlp_pkg::CSR_W'($urandom));
      write_config(8'd0, 16'd0, 16'd0, 1'b1, 2'b11);
      repeat (3) add_tick(1'b1, 1'b1);
      add_tick(1'b0, 1'b1);
      add_tick(1'b0, 1'b0);
      add_tick(1'b0, 1'b0);
      wait_idle();

      // filter lowered below a count already reached
      write_config(8'd6, 16'd2, 16'd1, 1'b0, 2'b00);
      repeat (3) add_tick(1'b0, 1'b0);
      wait_idle();
      write_reg(kdlp_pkg::REG_FILTER, kdlp_pkg::CSR_W'(2));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_run++;
      repeat (4) add_tick(1'b0, 1'b0);
      add_tick(1'b1, 1'b1);
      add_tick(1'b1, 1'b1);
      wait_idle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         send_idle = (p % 3) != 1;
         recv_idle = (p % 3) != 2;
         if (p == 0) begin
            write_config(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'b00);
            add_random_ticks(20);
         end else begin
            write_config(($urandom_range(0, 3) == 0) ? 8'd0 :
                            kdlp_pkg::FILT_W'($urandom_range(1, 4)),
                         ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                         16'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
            add_random_ticks(30);
         end
         wait_idle();
      end

      $display("%0d scan ticks over %0d register settings, %0d key events checked",
               ticks_sent, settings_run, events_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
